@@ hdl/clm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_pkg: shared types and constants of the comment and literal masker
// Holds the lexer modes, the character codes, the lexer state and the
// result record that the step logic passes to the top level.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Depth of the result queue; it must hold the two results of one step
  // on top of the two that may already wait.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [4:0] {
    MODE_CODE  = 5'b00001,
    MODE_LINE  = 5'b00010,
    MODE_BLOCK = 5'b00100,
    MODE_STR   = 5'b01000,
    MODE_CHR   = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       esc_tail;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] masked_byte;
    logic       prot;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic      valid_a;
    out_item_t item_a;
    logic      valid_b;
    out_item_t item_b;
  } lex_result_t;

  function automatic logic [7:0] mask_byte(input logic [7:0] b, input logic prot);
    return (prot && (b != CH_NL)) ? CH_SPACE : b;
  endfunction

endpackage

@@ hdl/clm_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_lexer: one step of the five-mode comment and literal lexer
// Takes one byte with its end mark and the current lexer state, and gives
// the next state and up to two result bytes (the held byte, then this byte).
// ----------------------------------------------------------------------------
module clm_lexer (
  input  logic                 [7:0] text_byte,
  input  logic                       end_of_text,
  input  clm_pkg::lex_state_t        state_cur,
  output clm_pkg::lex_state_t        state_nxt,
  output clm_pkg::lex_result_t       result
);

  clm_pkg::mode_t mode_w;
  logic           pair_done;
  logic           a_valid;
  logic           a_prot;
  logic           b_valid;
  logic           b_prot;
  logic           hold_c;
  logic           tail_w;
  logic           is_slash;
  logic           is_star;

  assign is_slash = (text_byte == clm_pkg::CH_SLASH);
  assign is_star  = (text_byte == clm_pkg::CH_STAR);

  always_comb begin
    mode_w    = state_cur.mode;
    pair_done = 1'b0;
    a_valid   = 1'b0;
    a_prot    = 1'b0;
    b_valid   = 1'b0;
    b_prot    = 1'b0;
    hold_c    = 1'b0;
    tail_w    = state_cur.esc_tail;

    // A held slash or star is resolved against the byte that follows it.
    if (state_cur.held_valid) begin
      a_valid = 1'b1;
      if (state_cur.mode == clm_pkg::MODE_CODE) begin
        if (is_slash || is_star) begin
          mode_w    = is_slash ? clm_pkg::MODE_LINE : clm_pkg::MODE_BLOCK;
          a_prot    = 1'b1;
          pair_done = 1'b1;
        end
      end else begin
        a_prot = 1'b1;
        if (is_slash) begin
          mode_w    = clm_pkg::MODE_CODE;
          pair_done = 1'b1;
        end
      end
    end

    if (pair_done) begin
      b_valid = 1'b1;
      b_prot  = 1'b1;
    end else if (tail_w) begin
      tail_w  = 1'b0;
      b_valid = 1'b1;
      b_prot  = 1'b1;
    end else begin
      case (mode_w)
        clm_pkg::MODE_CODE: begin
          if (is_slash) begin
            hold_c = 1'b1;
          end else if (text_byte == clm_pkg::CH_DQUOTE) begin
            mode_w  = clm_pkg::MODE_STR;
            b_valid = 1'b1;
            b_prot  = 1'b1;
          end else if (text_byte == clm_pkg::CH_SQUOTE) begin
            mode_w  = clm_pkg::MODE_CHR;
            b_valid = 1'b1;
            b_prot  = 1'b1;
          end else begin
            b_valid = 1'b1;
          end
        end
        clm_pkg::MODE_LINE: begin
          b_valid = 1'b1;
          if (text_byte == clm_pkg::CH_NL) begin
            mode_w = clm_pkg::MODE_CODE;
          end else begin
            b_prot = 1'b1;
          end
        end
        clm_pkg::MODE_BLOCK: begin
          if (is_star) begin
            hold_c = 1'b1;
          end else begin
            b_valid = 1'b1;
            b_prot  = 1'b1;
          end
        end
        clm_pkg::MODE_STR, clm_pkg::MODE_CHR: begin
          b_valid = 1'b1;
          b_prot  = 1'b1;
          if (text_byte == clm_pkg::CH_BSLASH) begin
            tail_w = 1'b1;
          end else if ((mode_w == clm_pkg::MODE_STR && text_byte == clm_pkg::CH_DQUOTE) ||
                       (mode_w == clm_pkg::MODE_CHR && text_byte == clm_pkg::CH_SQUOTE)) begin
            mode_w = clm_pkg::MODE_CODE;
          end
        end
        default: begin
          b_valid = 1'b1;
        end
      endcase
    end

    // At the end of the text a byte that was just held is flushed at once.
    if (end_of_text && hold_c) begin
      b_valid = 1'b1;
      b_prot  = (mode_w == clm_pkg::MODE_BLOCK);
    end

    if (end_of_text) begin
      state_nxt.mode       = clm_pkg::MODE_CODE;
      state_nxt.held_byte  = 8'h00;
      state_nxt.held_valid = 1'b0;
      state_nxt.esc_tail   = 1'b0;
    end else begin
      state_nxt.mode       = mode_w;
      state_nxt.held_byte  = hold_c ? text_byte : state_cur.held_byte;
      state_nxt.held_valid = hold_c;
      state_nxt.esc_tail   = tail_w;
    end

    result.valid_a            = a_valid;
    result.item_a.masked_byte = clm_pkg::mask_byte(state_cur.held_byte, a_prot);
    result.item_a.prot        = a_prot;
    result.item_a.last        = end_of_text && !b_valid;
    result.valid_b            = b_valid;
    result.item_b.masked_byte = clm_pkg::mask_byte(text_byte, b_prot);
    result.item_b.prot        = b_prot;
    result.item_b.last        = end_of_text;
  end

endmodule

@@ hdl/comment_and_literal_masker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_and_literal_masker: masks comments and literals in C source text
// Lexes a byte stream and gives every byte back with a protected flag;
// protected bytes other than newline come back as spaces.
// ----------------------------------------------------------------------------
//  Channel | Ports            | Contents
//  --------+------------------+----------------------------------------------
//  input   | in_t*            | tdata: text_byte[7:0]; tlast: end_of_text
//  result  | out_t*           | tdata: masked_byte[7:0]; tuser: in_protected;
//          |                  | tlast: last_of_text
//
// An input beat is registered, then lexed combinationally; its zero to two
// result beats are written to a four-entry queue, which the result side
// drains one beat per cycle while out_tready is high. A beat passes the input
// register and then the queue. A new input beat is taken every cycle while
// the queue holds at most two beats, giving one byte per cycle sustained if
// the output keeps up; a two-result step fills two entries. Reset (rst_n low,
// synchronous) empties the queue and returns the lexer to code mode.
// ----------------------------------------------------------------------------
module comment_and_literal_masker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] masked_byte
  output logic       out_tuser,  // [0] in_protected
  output logic       out_tlast
);

  logic                 in_v_r;
  logic [7:0]           in_byte_r;
  logic                 in_eot_r;
  clm_pkg::lex_state_t  state_r;
  clm_pkg::lex_state_t  state_nxt;
  clm_pkg::lex_result_t result;
  clm_pkg::out_item_t   q_data_r [clm_pkg::QDepth];
  logic [clm_pkg::QAw-1:0] wr_ptr_r;
  logic [clm_pkg::QAw-1:0] rd_ptr_r;
  logic [clm_pkg::QAw:0]   count_r;
  logic                 step;
  logic                 pop;
  logic [1:0]           push_n;
  clm_pkg::out_item_t   item_out;

  // Room for two results is checked before a step fires.
  assign step      = in_v_r && (count_r <= (clm_pkg::QAw+1)'(clm_pkg::QDepth - 2));
  assign in_tready = !in_v_r || step;
  assign pop       = out_tvalid && out_tready;
  assign push_n    = step ? ({1'b0, result.valid_a} + {1'b0, result.valid_b}) : 2'd0;

  clm_lexer u_lexer (
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .state_cur   (state_r),
    .state_nxt   (state_nxt),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      state_r  <= '{mode: clm_pkg::MODE_CODE, held_byte: 8'h00, held_valid: 1'b0,
                    esc_tail: 1'b0};
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (step) begin
        state_r <= state_nxt;
      end
      wr_ptr_r <= wr_ptr_r + push_n[clm_pkg::QAw-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + {{(clm_pkg::QAw-1){1'b0}}, push_n}
                         - {{clm_pkg::QAw{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
    if (step) begin
      if (result.valid_a) begin
        q_data_r[wr_ptr_r] <= result.item_a;
        if (result.valid_b) begin
          q_data_r[wr_ptr_r + 1'b1] <= result.item_b;
        end
      end else if (result.valid_b) begin
        q_data_r[wr_ptr_r] <= result.item_b;
      end
    end
  end

  assign item_out   = q_data_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = item_out.masked_byte;
  assign out_tuser  = item_out.prot;
  assign out_tlast  = item_out.last;

endmodule
